@@ rtl/rssg_pkg.sv @@
// Shared constants, codes and control types for the road scanline span generator.
package rssg_pkg;

  localparam int SCREEN_WIDTH   = 320;
  localparam int SCREEN_HEIGHT  = 240;
  localparam int MAX_SEGMENTS   = 2048;
  localparam int SEGMENT_LENGTH = 200;
  localparam int STRIPE_LENGTH  = 600;
  localparam int LANES          = 3;

  localparam int ROW_DEPTH    = 120;
  localparam int SHADES       = 24;
  localparam int MAX_SPANS    = 5;
  localparam int RUMBLE_Q16   = 88474;
  localparam int LANE_Q16     = 1638;
  localparam int MIN_STEP_Q14 = 2458;
  localparam int ONE_Q14      = 16384;

  localparam int MAT_GRASS  = 0;
  localparam int MAT_RUMBLE = 2;
  localparam int MAT_TARMAC = 4;
  localparam int MAT_LANE   = 6;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_DATA_W = 12;

  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int ROW_AW = $clog2(ROW_DEPTH);
  localparam int SEG_AW = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int D_W    = 20;
  localparam int XW     = 36;

  // Reciprocals for the constant divisions; one compare corrects the quotient.
  localparam int RECIP_SH       = 23;
  localparam int SEG_RECIP      = (1 << RECIP_SH) / SEGMENT_LENGTH;
  localparam int SEG_RECIP_W    = $clog2(SEG_RECIP + 1);
  localparam int STRIPE_RECIP   = (1 << RECIP_SH) / STRIPE_LENGTH;
  localparam int STRIPE_RECIP_W = $clog2(STRIPE_RECIP + 1);
  localparam int QSEG_W         = $clog2(((1 << D_W) - 1) / SEGMENT_LENGTH + 1);
  localparam int QBIT_W         = $clog2(QSEG_W);
  localparam int LANE_SH        = 30;
  localparam int LANE_RECIP     = (1 << LANE_SH) / LANES;
  localparam int LANE_RECIP_W   = $clog2(LANE_RECIP + 1);
  localparam int LR_W           = $clog2(2 * LANES + 1);
  localparam int NUM_CAND       = LANES + 2;
  localparam int K_W            = $clog2(NUM_CAND);
  localparam int N_W            = $clog2(MAX_SPANS + 1);

  typedef enum logic [1:0] {
    FUNC_ROW_WR = 2'd0,
    FUNC_SEG_WR = 2'd1,
    FUNC_FRAME  = 2'd2,
    FUNC_DRAW   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_GRASS  = 3'd0,
    KIND_RUMBLE = 3'd1,
    KIND_TARMAC = 3'd2,
    KIND_LANE   = 3'd3,
    KIND_END    = 3'd4
  } span_kind_e;

  typedef enum logic {
    CFG_TABLE_ENTRIES = 1'b0,
    CFG_SEGMENT_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_MUL,
    ST_CORR,
    ST_SPAN,
    ST_FLUSH,
    ST_MOD,
    ST_SEG,
    ST_UPD,
    ST_END
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_row;
    logic mult;
    logic corr;
    logic span;
    logic flush;
    logic mod_step;
    logic seg_read;
    logic update;
    logic end_rec;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  draw_end;
    logic  span_done;
    logic  out_free;
    logic  mod_done;
  } dp_status_t;

endpackage

@@ rtl/rssg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rssg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rssg_ctrl.sv @@
// Sequencing state machine for the span generator.
module rssg_ctrl import rssg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.func == FUNC_DRAW) begin
          state_d = status_i.draw_end ? ST_END : ST_ROW;
        end
      end
      ST_ROW:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_CORR;
      ST_CORR:  state_d = ST_SPAN;
      ST_SPAN: begin
        if (status_i.span_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status_i.mod_done) begin
          state_d = ST_SEG;
        end
      end
      ST_SEG:   state_d = ST_UPD;
      ST_UPD:   state_d = ST_IDLE;
      ST_END: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_ROW:   cmd_o.load_row = 1'b1;
      ST_MUL:   cmd_o.mult     = 1'b1;
      ST_CORR:  cmd_o.corr     = 1'b1;
      ST_SPAN:  cmd_o.span     = 1'b1;
      ST_FLUSH: cmd_o.flush    = 1'b1;
      ST_MOD:   cmd_o.mod_step = 1'b1;
      ST_SEG:   cmd_o.seg_read = 1'b1;
      ST_UPD:   cmd_o.update   = 1'b1;
      ST_END:   cmd_o.end_rec  = 1'b1;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

@@ rtl/rssg_dpath.sv @@
// Datapath: tables, road state, span arithmetic, remainder unit and output registers.
module rssg_dpath import rssg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [1:0]        func_i,
  input  logic [10:0]       index_i,
  input  logic [15:0]       row_distance_i,
  input  logic [15:0]       row_half_width_i,
  input  logic [4:0]        row_shade_i,
  input  logic [15:0]       seg_curve_i,
  input  logic [15:0]       seg_hill_i,
  input  logic [18:0]       frame_position_i,
  input  logic [15:0]       player_offset_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        row_o,
  output logic [2:0]        span_kind_o,
  output logic [8:0]        left_o,
  output logic [8:0]        right_o,
  output logic [7:0]        color_o,
  output logic              last_o
);

  // Configuration and road state.
  logic [6:0]        entries_q;
  logic [11:0]       seg_count_q;
  logic [18:0]       pos_q;
  logic [15:0]       off_q;
  logic signed [31:0] accum_q;
  logic signed [31:0] slope_q;
  logic [15:0]       walk_q;
  logic [ROW_W-1:0]  row_q;
  logic              road_done_q;

  // Per-row working registers.
  logic [15:0]       w_q;
  logic [4:0]        shade_q;
  logic [D_W-1:0]    d_q;
  logic signed [32:0] poff_q;
  logic [26:0]       rum_q;
  logic [20:0]       lh_q;
  logic [QSEG_W-1:0] q0seg_q;
  logic [D_W-1:0]    q0str_q;
  logic [26:0]       q0lane_q;
  logic signed [XW-1:0] centre_q;
  logic [QSEG_W-1:0] qseg_q;
  logic              light_q;
  logic [26:0]       q2_q;
  logic [LR_W-1:0]   r2_q;
  logic [27:0]       loff_q;
  logic [LR_W-1:0]   lacc_q;
  logic [K_W-1:0]    k_q;
  logic [N_W-1:0]    n_q;
  logic [CNT_W-1:0]  mod_rem_q;
  logic [QBIT_W-1:0] mod_bit_q;

  // Pending span and output register.
  logic              pend_v_q;
  span_kind_e        pend_kind_q;
  logic [COL_W-1:0]  pend_left_q, pend_right_q;
  logic [7:0]        pend_color_q;
  logic              out_valid_q;
  logic [7:0]        o_row_q;
  span_kind_e        o_kind_q;
  logic [8:0]        o_left_q, o_right_q;
  logic [7:0]        o_color_q;
  logic              o_last_q;

  logic [36:0] row_rdata;
  logic [31:0] seg_rdata;
  logic        row_we, seg_we;

  assign row_we = cmd_i.accept && func_e'(func_i) == FUNC_ROW_WR &&
                  32'(index_i) < 32'(ROW_DEPTH);
  assign seg_we = cmd_i.accept && func_e'(func_i) == FUNC_SEG_WR &&
                  32'(index_i) < 32'(MAX_SEGMENTS);

  // Table entry for the row about to be drawn.
  logic [7:0] entry, limit;
  assign entry = walk_q[15:8];
  assign limit = (entries_q < 7'(ROW_DEPTH)) ? 8'(entries_q) : 8'(ROW_DEPTH);

  rssg_ram #(.WIDTH(37), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (index_i[ROW_AW-1:0]),
    .wdata_i ({row_shade_i, row_half_width_i, row_distance_i}),
    .re_i    (cmd_i.accept),
    .raddr_i (entry[ROW_AW-1:0]),
    .rdata_o (row_rdata)
  );

  rssg_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (index_i[SEG_AW-1:0]),
    .wdata_i ({seg_hill_i, seg_curve_i}),
    .re_i    (cmd_i.seg_read),
    .raddr_i (mod_rem_q[SEG_AW-1:0]),
    .rdata_o (seg_rdata)
  );

  // Multiplier stage.
  logic signed [32:0] poff_d;
  logic [32:0] rum_full;
  logic [26:0] lh_full;
  logic [D_W+SEG_RECIP_W-1:0] dseg_full;
  logic [D_W+STRIPE_RECIP_W-1:0] dstr_full;
  logic [26:0] lane_x;
  logic [27+LANE_RECIP_W-1:0] lane_full;

  assign poff_d    = $signed(off_q) * $signed({1'b0, w_q});
  assign rum_full  = 33'(w_q) * 33'(RUMBLE_Q16);
  assign lh_full   = 27'(w_q) * 27'(LANE_Q16);
  assign dseg_full = (D_W+SEG_RECIP_W)'(d_q) * (D_W+SEG_RECIP_W)'(SEG_RECIP);
  assign dstr_full = (D_W+STRIPE_RECIP_W)'(d_q) * (D_W+STRIPE_RECIP_W)'(STRIPE_RECIP);
  assign lane_x    = {w_q, 11'b0};
  assign lane_full = (27+LANE_RECIP_W)'(lane_x) * (27+LANE_RECIP_W)'(LANE_RECIP);

  // Quotient correction stage.
  logic [31:0] rseg, rstr, rlane;
  logic        lane_ge;
  assign rseg    = 32'(d_q) - 32'(q0seg_q) * 32'(SEGMENT_LENGTH);
  assign rstr    = 32'(d_q) - 32'(q0str_q) * 32'(STRIPE_LENGTH);
  assign rlane   = 32'(lane_x) - 32'(q0lane_q) * 32'(LANES);
  assign lane_ge = rlane >= 32'(LANES);

  // Span candidate selected by k_q.
  logic signed [XW-1:0] tarm_s, rum_s, lh_s, loff_s, lx_s, x1, x2;
  logic signed [XW-1:0] lft_s, rgt_raw, rgt_s;
  logic [2:0]  mat_c;
  logic [7:0]  color_c;
  span_kind_e  kind_c;
  logic        want_c, emit_c, out_free, stall, adv;

  assign tarm_s = $signed(XW'({w_q, 10'b0}));
  assign rum_s  = $signed(XW'(rum_q));
  assign lh_s   = $signed(XW'(lh_q));
  assign loff_s = $signed(XW'(loff_q));
  assign lx_s   = centre_q - tarm_s + loff_s;

  always_comb begin
    want_c = 1'b1;
    if (k_q == K_W'(0)) begin
      kind_c = KIND_GRASS;
      x1     = '0;
      x2     = $signed(XW'(SCREEN_WIDTH)) <<< 16;
      mat_c  = 3'(MAT_GRASS) + 3'(light_q);
    end else if (k_q == K_W'(1)) begin
      kind_c = KIND_RUMBLE;
      x1     = centre_q - rum_s;
      x2     = centre_q + rum_s;
      mat_c  = 3'(MAT_RUMBLE) + 3'(light_q);
    end else if (k_q == K_W'(2)) begin
      kind_c = KIND_TARMAC;
      x1     = centre_q - tarm_s;
      x2     = centre_q + tarm_s;
      mat_c  = 3'(MAT_TARMAC) + 3'(light_q);
    end else begin
      kind_c = KIND_LANE;
      x1     = lx_s - lh_s;
      x2     = lx_s + lh_s;
      mat_c  = 3'(MAT_LANE);
      want_c = light_q;
    end
  end

  assign color_c  = 8'(mat_c) * 8'(SHADES) + 8'(shade_q);
  assign lft_s    = x1[XW-1] ? '0 : (x1 >>> 16);
  assign rgt_raw  = x2 >>> 16;
  assign rgt_s    = (rgt_raw > $signed(XW'(SCREEN_WIDTH))) ? $signed(XW'(SCREEN_WIDTH)) : rgt_raw;
  assign emit_c   = want_c && (rgt_s > lft_s) && (n_q < N_W'(MAX_SPANS));
  assign out_free = !out_valid_q || out_ready_i;
  assign stall    = emit_c && pend_v_q && !out_free;
  assign adv      = cmd_i.span && !stall;

  // Running lane offset: floor(2*T*i/LANES) built from quotient and remainder.
  logic [LR_W-1:0] lsum;
  logic            lwrap;
  assign lsum  = lacc_q + r2_q;
  assign lwrap = lsum >= LR_W'(LANES);

  // One restoring step of the segment remainder.
  logic [CNT_W-1:0] seg_cnt;
  logic [CNT_W:0]   mod_sh;
  assign seg_cnt = (seg_count_q == '0) ? CNT_W'(1) :
                   (seg_count_q > 12'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) :
                   CNT_W'(seg_count_q);
  assign mod_sh  = {mod_rem_q, qseg_q[mod_bit_q]};

  // Road state update.
  logic signed [31:0] slope_d;
  logic signed [16:0] step_raw, step_c;
  logic [16:0]        walk_sum;
  assign slope_d  = slope_q + 32'($signed(seg_rdata[15:0]));
  assign step_raw = 17'sd16384 + 17'($signed(seg_rdata[31:16]));
  assign step_c   = (step_raw < 17'sd2458) ? 17'sd2458 : step_raw;
  assign walk_sum = 17'(walk_q) + 17'(step_c[15:6]);

  // Output register writes.
  logic push, flush_wr, end_wr, out_wr;
  assign push     = adv && emit_c && pend_v_q;
  assign flush_wr = cmd_i.flush && out_free;
  assign end_wr   = cmd_i.end_rec && out_free;
  assign out_wr   = push || flush_wr || end_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= 7'(ROW_DEPTH);
      seg_count_q <= 12'd1;
      pos_q       <= '0;
      off_q       <= '0;
      accum_q     <= 32'(SCREEN_WIDTH / 2) << 16;
      slope_q     <= '0;
      walk_q      <= '0;
      row_q       <= ROW_W'(SCREEN_HEIGHT - 1);
      road_done_q <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mod_bit_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_TABLE_ENTRIES: entries_q   <= cfg_data_i[6:0];
          CFG_SEGMENT_COUNT: seg_count_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && func_e'(func_i) == FUNC_FRAME) begin
        pos_q       <= frame_position_i;
        off_q       <= player_offset_i;
        accum_q     <= 32'(SCREEN_WIDTH / 2) << 16;
        slope_q     <= '0;
        walk_q      <= '0;
        row_q       <= ROW_W'(SCREEN_HEIGHT - 1);
        road_done_q <= 1'b0;
      end
      if (cmd_i.corr) begin
        k_q       <= '0;
        n_q       <= '0;
        mod_bit_q <= QBIT_W'(QSEG_W - 1);
      end
      if (adv) begin
        k_q <= k_q + K_W'(1);
        if (emit_c) begin
          pend_v_q <= 1'b1;
          n_q      <= n_q + N_W'(1);
        end
      end
      if (flush_wr) begin
        pend_v_q <= 1'b0;
      end
      if (cmd_i.mod_step) begin
        mod_bit_q <= mod_bit_q - QBIT_W'(1);
      end
      if (end_wr) begin
        road_done_q <= 1'b1;
      end
      if (cmd_i.update) begin
        slope_q <= slope_d;
        accum_q <= accum_q + slope_d;
        walk_q  <= walk_sum[16] ? 16'hFFFF : walk_sum[15:0];
        row_q   <= row_q - ROW_W'(1);
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      w_q     <= row_rdata[31:16];
      shade_q <= row_rdata[36:32];
      d_q     <= D_W'(pos_q) + D_W'(row_rdata[15:0]);
    end
    if (cmd_i.mult) begin
      poff_q   <= poff_d;
      rum_q    <= rum_full[32:6];
      lh_q     <= lh_full[26:6];
      q0seg_q  <= QSEG_W'(dseg_full >> RECIP_SH);
      q0str_q  <= D_W'(dstr_full >> RECIP_SH);
      q0lane_q <= 27'(lane_full >> LANE_SH);
    end
    if (cmd_i.corr) begin
      centre_q  <= XW'(accum_q) - XW'(poff_q >>> 2);
      qseg_q    <= q0seg_q + QSEG_W'(rseg >= 32'(SEGMENT_LENGTH));
      light_q   <= q0str_q[0] ^ (rstr >= 32'(STRIPE_LENGTH));
      q2_q      <= q0lane_q + 27'(lane_ge);
      r2_q      <= LR_W'(lane_ge ? rlane - 32'(LANES) : rlane);
      loff_q    <= '0;
      lacc_q    <= '0;
      mod_rem_q <= '0;
    end
    if (adv && k_q >= K_W'(2)) begin
      loff_q <= loff_q + 28'(q2_q) + 28'(lwrap);
      lacc_q <= lwrap ? lsum - LR_W'(LANES) : lsum;
    end
    if (adv && emit_c) begin
      pend_kind_q  <= kind_c;
      pend_left_q  <= COL_W'(lft_s);
      pend_right_q <= COL_W'(rgt_s);
      pend_color_q <= color_c;
    end
    if (cmd_i.mod_step) begin
      mod_rem_q <= (mod_sh >= {1'b0, seg_cnt}) ? CNT_W'(mod_sh - {1'b0, seg_cnt})
                                                : CNT_W'(mod_sh);
    end
    if (push || flush_wr) begin
      o_row_q   <= 8'(row_q);
      o_kind_q  <= pend_kind_q;
      o_left_q  <= 9'(pend_left_q);
      o_right_q <= 9'(pend_right_q);
      o_color_q <= pend_color_q;
      o_last_q  <= flush_wr;
    end else if (end_wr) begin
      o_row_q   <= 8'(row_q);
      o_kind_q  <= KIND_END;
      o_left_q  <= '0;
      o_right_q <= '0;
      o_color_q <= '0;
      o_last_q  <= 1'b1;
    end
  end

  assign status_o.func      = func_e'(func_i);
  assign status_o.draw_end  = road_done_q || (row_q < ROW_W'(SCREEN_HEIGHT / 2)) ||
                              (entry >= limit);
  assign status_o.span_done = adv && (k_q == K_W'(NUM_CAND - 1));
  assign status_o.out_free  = out_free;
  assign status_o.mod_done  = cmd_i.mod_step && (mod_bit_q == '0);

  assign out_valid_o = out_valid_q;
  assign row_o       = o_row_q;
  assign span_kind_o = o_kind_q;
  assign left_o      = o_left_q;
  assign right_o     = o_right_q;
  assign color_o     = o_color_q;
  assign last_o      = o_last_q;

`ifndef SYNTHESIS
  a_span_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(MAX_SPANS))
    else $error("more spans counted than a row may carry");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while its span waits");

  a_span_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_kind_q != KIND_END) |-> (o_left_q < o_right_q))
    else $error("empty span presented");

  a_walk_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (walk_q >= $past(walk_q)))
    else $error("walk index went backwards");
`endif

endmodule

@@ rtl/road_scanline_span_generator.sv @@
// Top level of the pseudo-3D road scanline span generator.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid_i/tready_o       tdata request fields, tuser func
//  m_axis    out        m_axis_tvalid_o/tready_i       tdata span fields, tuser kind, tlast
//  cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// Table writes and frame starts are taken while idle. A draw request that ends the road
// goes to the end state, which writes the end record once the output register is free.
// A drawn row passes through four set-up and arithmetic steps (acceptance, table read,
// multiply, quotient correction), the span walk over the five span candidates, a flush
// of the last span, the serial remainder unit that picks the track segment, one quotient
// bit per cycle, then the segment table read and the state update.
// Reset is asynchronous and active low; the tables are not cleared and hold garbage
// until written, so no clearing pass follows reset.
// A stalled output holds the span walk only when a new span would need the output
// register; the span already waiting keeps its place and nothing is lost.
module road_scanline_span_generator import rssg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // index, row_distance, row_half_width, row_shade, seg_curve, seg_hill,
  // frame_position, player_offset (lowest bit up), zero filled to 120 bits
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // row, left, right, color (lowest bit up), zero filled to 40 bits
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // span_kind
  output logic [2:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [7:0] row;
  logic [8:0] left, right;
  logic [7:0] color;

  // Configuration writes are always taken; the user must send them only while the block is idle; it does not check.
  assign cfg_ready_o = 1'b1;

  rssg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rssg_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .func_i           (s_axis_tuser_i),
    .index_i          (s_axis_tdata_i[10:0]),
    .row_distance_i   (s_axis_tdata_i[26:11]),
    .row_half_width_i (s_axis_tdata_i[42:27]),
    .row_shade_i      (s_axis_tdata_i[47:43]),
    .seg_curve_i      (s_axis_tdata_i[63:48]),
    .seg_hill_i       (s_axis_tdata_i[79:64]),
    .frame_position_i (s_axis_tdata_i[98:80]),
    .player_offset_i  (s_axis_tdata_i[114:99]),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .row_o            (row),
    .span_kind_o      (m_axis_tuser_o),
    .left_o           (left),
    .right_o          (right),
    .color_o          (color),
    .last_o           (m_axis_tlast_o)
  );

  // Output fields packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata_o = {6'b0, color, right, left, row};

endmodule
